@@ src/deq_pkg.sv @@
// Package for the double-ended queue: action and status codes, controller
// states and the operation struct passed from pointer logic to the top level.
// No dependencies.
package deq_pkg;

  typedef enum logic [1:0] {
    ACT_PUSH_BACK  = 2'd0,
    ACT_PUSH_FRONT = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  // Decoded operation for the transaction being accepted
  typedef struct packed {
    logic    wr_en;
    logic    rd_en;
    status_t status;
  } deq_op_t;

  localparam logic signed [31:0] NEG_ONE = -32'sd1;

endpackage

@@ src/double_ended_queue.sv @@
// Top level of the bounded double-ended queue: controller, output register,
// pointer logic and slot memory. Depends on deq_pkg, deq_ptr and deq_ram.
//
//   channel | signals                          | direction
//   in      | in_valid in_ready action value   | item into the deque
//   out     | out_valid out_ready popped status occupancy | one result per item
//
// A push, or a pop that finds the deque empty, gives its result in the cycle
// after acceptance; a pop of a stored word passes the slot memory's read
// register, then enters the output register once free. A new item is taken
// once the previous one has reached the output register and that register is
// free or being emptied. Reset clears the pointer, the count and the controller;
// the slot memory needs no clearing. A stalled output holds all results in place.
module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] popped,
  output logic [1:0]         status,
  output logic [4:0]         occupancy
);
  import deq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  state_t             state, state_next;
  deq_op_t            op;
  logic [IW-1:0]      addr;
  logic [CW-1:0]      count_next;
  logic signed [31:0] rd_data;
  logic               out_free, fire, load_now, load_rd;

  deq_ptr #(.DEPTH(DEPTH), .IW(IW), .CW(CW)) u_ptr (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .action     (action),
    .op         (op),
    .addr       (addr),
    .count_next (count_next)
  );

  deq_ram #(.DEPTH(DEPTH), .IW(IW)) u_ram (
    .clk     (clk),
    .wr_en   (op.wr_en),
    .rd_en   (op.rd_en),
    .addr    (addr),
    .wr_data (value),
    .rd_data (rd_data)
  );

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Accept when idle and the output slot can take a result
  always_comb begin
    out_free   = !out_valid || out_ready;
    in_ready   = (state == S_IDLE) && out_free;
    fire       = in_valid && in_ready;
    load_now   = 1'b0;
    load_rd    = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (fire) begin
          if (op.rd_en) begin
            state_next = S_READ;
          end else begin
            load_now = 1'b1;
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          load_rd    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Drop the valid once the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_now || load_rd) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Capture the result transaction
  always_ff @(posedge clk) begin
    if (load_now) begin
      popped    <= NEG_ONE;
      status    <= op.status;
      occupancy <= 5'(count_next);
    end else if (load_rd) begin
      popped    <= rd_data;
      status    <= ST_OK;
      occupancy <= 5'(count_next);
    end
  end

endmodule

@@ src/deq_ram.sv @@
// Slot storage for the double-ended queue: one synchronous memory with a
// shared address, registered read data held between reads.
// Depends on nothing.
module deq_ram #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic                rd_en,
  input  logic [IW-1:0]       addr,
  input  logic signed [31:0]  wr_data,
  output logic signed [31:0]  rd_data
);

  logic signed [31:0] mem [DEPTH];

  // Write one slot
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  // Read one slot; hold the data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

@@ src/deq_ptr.sv @@
// Front pointer and element count of the double-ended queue: decodes the
// action, picks the slot address and updates the ring state.
// Depends on deq_pkg.
module deq_ptr #(
  parameter int DEPTH = 16,
  parameter int IW    = 4,
  parameter int CW    = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  logic [1:0]      action,
  output deq_pkg::deq_op_t op,
  output logic [IW-1:0]   addr,
  output logic [CW-1:0]   count_next
);
  import deq_pkg::*;

  localparam int SW = IW + 1;

  logic [IW-1:0] front, front_next;
  logic [CW-1:0] count;
  logic          full, empty;
  logic [IW-1:0] front_inc, front_dec, tail, last;
  logic [SW-1:0] sum, sum_m1;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  // Ring arithmetic: every sum stays below twice the depth
  assign front_inc = (front == IW'(DEPTH - 1)) ? '0 : front + 1'b1;
  assign front_dec = (front == '0) ? IW'(DEPTH - 1) : front - 1'b1;
  assign sum       = SW'(front) + SW'(count);
  assign sum_m1    = sum - 1'b1;
  assign tail      = (sum >= SW'(DEPTH)) ? IW'(sum - SW'(DEPTH)) : sum[IW-1:0];
  assign last      = (sum_m1 >= SW'(DEPTH)) ? IW'(sum_m1 - SW'(DEPTH)) : sum_m1[IW-1:0];

  // Decode the action against the current fill
  always_comb begin
    op         = '{wr_en: 1'b0, rd_en: 1'b0, status: ST_OK};
    addr       = front;
    front_next = front;
    count_next = count;
    if (fire) begin
      case (action_t'(action))
        ACT_PUSH_BACK: begin
          if (full) begin
            op.status = ST_FULL;
          end else begin
            op.wr_en   = 1'b1;
            addr       = tail;
            count_next = count + 1'b1;
          end
        end
        ACT_PUSH_FRONT: begin
          if (full) begin
            op.status = ST_FULL;
          end else begin
            op.wr_en   = 1'b1;
            addr       = front_dec;
            front_next = front_dec;
            count_next = count + 1'b1;
          end
        end
        ACT_POP_FRONT: begin
          if (empty) begin
            op.status = ST_EMPTY;
          end else begin
            op.rd_en   = 1'b1;
            addr       = front;
            front_next = front_inc;
            count_next = count - 1'b1;
          end
        end
        ACT_POP_BACK: begin
          if (empty) begin
            op.status = ST_EMPTY;
          end else begin
            op.rd_en   = 1'b1;
            addr       = last;
            count_next = count - 1'b1;
          end
        end
        default: begin
          op.status = ST_OK;
        end
      endcase
    end
  end

  // Advance pointer and count on each transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else begin
      front <= front_next;
      count <= count_next;
    end
  end

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for double_ended_queue: directed table, then biased random traffic.
// Keeps its own deque model and checks every result in order. Depends on deq_pkg.
module testbench;
  import deq_pkg::*;

  localparam int DEPTH          = 16;
  localparam int RANDOM_ITEMS   = 550;
  localparam int HOLD_CYCLES    = 120;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WANT_DEPTH     = 32;

  typedef struct packed {
    logic [31:0] popped;
    status_t     status;
    logic [4:0]  occupancy;
  } deq_result_t;

  typedef struct packed {
    action_t     act;
    logic [31:0] word;
    logic        typed;
    deq_result_t want;
  } stim_row_t;

  localparam deq_result_t NOT_TYPED = '0;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [1:0]         action    = ACT_PUSH_BACK;
  logic signed [31:0] value     = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] popped;
  logic [1:0]         status;
  logic [4:0]         occupancy;

  // Deque model: ring of words, front slot and word count
  logic [31:0] model_slot [DEPTH];
  int          model_front = 0;
  int          model_count = 0;

  // Expected results in acceptance order: ring with write and read counters
  deq_result_t want_ring [WANT_DEPTH];
  int          want_wr        = 0;
  int          want_rd        = 0;
  int          mismatch_count = 0;
  int          burst_left     = 0;
  int          idle_cycles    = 0;
  bit          hold_request   = 1'b0;

  // Directed rows: empty pops, extremes, fill to full, pushes on full, two pops
  stim_row_t directed_rows [26] = '{
    '{ACT_POP_FRONT,  32'h0000_0000, 1'b1, '{NEG_ONE,       ST_EMPTY, 5'd0}},
    '{ACT_POP_BACK,   32'h5A5A_5A5A, 1'b1, '{NEG_ONE,       ST_EMPTY, 5'd0}},
    '{ACT_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, '{NEG_ONE,       ST_OK,    5'd1}},
    '{ACT_PUSH_FRONT, 32'h8000_0000, 1'b1, '{NEG_ONE,       ST_OK,    5'd2}},
    '{ACT_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h8000_0000, ST_OK,    5'd1}},
    '{ACT_POP_BACK,   32'hFFFF_FFFF, 1'b1, '{32'h7FFF_FFFF, ST_OK,    5'd0}},
    '{ACT_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, NOT_TYPED},
    '{ACT_PUSH_BACK,  32'h0000_0000, 1'b0, NOT_TYPED},
    '{ACT_PUSH_FRONT, 32'h0000_0003, 1'b0, NOT_TYPED},
    '{ACT_PUSH_BACK,  32'h0000_0004, 1'b0, NOT_TYPED},
    '{ACT_PUSH_FRONT, 32'hA5A5_A5A5, 1'b0, NOT_TYPED},
    '{ACT_PUSH_BACK,  32'h5A5A_5A5A, 1'b0, NOT_TYPED},
    '{ACT_PUSH_FRONT, 32'h1234_5678, 1'b0, NOT_TYPED},
    '{ACT_PUSH_BACK,  32'h8765_4321, 1'b0, NOT_TYPED},
    '{ACT_PUSH_FRONT, 32'h0F0F_0F0F, 1'b0, NOT_TYPED},
    '{ACT_PUSH_BACK,  32'hF0F0_F0F0, 1'b0, NOT_TYPED},
    '{ACT_PUSH_FRONT, 32'h0000_000B, 1'b0, NOT_TYPED},
    '{ACT_PUSH_BACK,  32'h0000_000C, 1'b0, NOT_TYPED},
    '{ACT_PUSH_FRONT, 32'hDEAD_0000, 1'b0, NOT_TYPED},
    '{ACT_PUSH_BACK,  32'h0000_BEEF, 1'b0, NOT_TYPED},
    '{ACT_PUSH_FRONT, 32'h8000_0001, 1'b0, NOT_TYPED},
    '{ACT_PUSH_BACK,  32'h7FFF_FFFE, 1'b0, NOT_TYPED},
    '{ACT_PUSH_BACK,  32'h1111_1111, 1'b1, '{NEG_ONE,       ST_FULL,  5'd16}},
    '{ACT_PUSH_FRONT, 32'h2222_2222, 1'b1, '{NEG_ONE,       ST_FULL,  5'd16}},
    '{ACT_POP_FRONT,  32'h0000_0000, 1'b0, NOT_TYPED},
    '{ACT_POP_BACK,   32'h0000_0000, 1'b0, NOT_TYPED}
  };

  double_ended_queue #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .popped   (popped),
    .status   (status),
    .occupancy(occupancy)
  );

  always #5 clk = ~clk;

  // Apply one transaction to the deque model and return its result
  function automatic deq_result_t deque_apply(action_t act, logic [31:0] word);
    deq_result_t res;
    res.popped = NEG_ONE;
    res.status = ST_OK;
    case (act)
      ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
        if (model_count >= DEPTH) begin
          res.status = ST_FULL;
        end else if (act == ACT_PUSH_BACK) begin
          model_slot[(model_front + model_count) % DEPTH] = word;
          model_count++;
        end else begin
          model_front = (model_front + DEPTH - 1) % DEPTH;
          model_slot[model_front] = word;
          model_count++;
        end
      end
      default: begin
        if (model_count == 0) begin
          res.status = ST_EMPTY;
        end else if (act == ACT_POP_FRONT) begin
          res.popped  = model_slot[model_front];
          model_front = (model_front + 1) % DEPTH;
          model_count--;
        end else begin
          res.popped = model_slot[(model_front + model_count - 1) % DEPTH];
          model_count--;
        end
      end
    endcase
    res.occupancy = model_count[4:0];
    return res;
  endfunction

  task automatic log_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH: %s", what);
  endtask

  // Store one expected result behind the others
  task automatic want_store(deq_result_t res);
    if (want_wr - want_rd >= WANT_DEPTH) begin
      log_mismatch("too many results outstanding");
    end else begin
      want_ring[want_wr % WANT_DEPTH] = res;
      want_wr++;
    end
  endtask

  // Offer one transaction in bursts with random gaps; record its result once taken
  task automatic send_item(action_t act, logic [31:0] word, logic typed,
                           deq_result_t want);
    deq_result_t predicted;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 10);
    end
    in_valid <= 1'b1;
    action   <= act;
    value    <= word;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    predicted = deque_apply(act, word);
    want_store(typed ? want : predicted);
  endtask

  // Stimulus: reset, directed table, biased random traffic, drain
  initial begin
    int      target_fill;
    bit      grow;
    action_t act;
    target_fill = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].act, directed_rows[i].word, directed_rows[i].typed,
                directed_rows[i].want);
    end

    // Swing the fill level between empty, full and in between
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0:       target_fill = 0;
          1:       target_fill = DEPTH;
          default: target_fill = $urandom_range(1, DEPTH - 1);
        endcase
      end
      if (n == 120 || n == 400) hold_request = 1'b1;
      if (model_count < target_fill) grow = ($urandom_range(0, 3) != 0);
      else grow = ($urandom_range(0, 3) == 0);
      if (grow) act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
      else act = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
      send_item(act, $urandom, 1'b0, NOT_TYPED);
    end

    in_valid <= 1'b0;
    while (want_wr != want_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver: picks one of four stall patterns and redraws it periodically; long hold-off on request
  initial begin
    int recv_cycle;
    int stall_mode;
    recv_cycle = 0;
    stall_mode = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (recv_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 1) == 1);
          2:       out_ready <= (recv_cycle % 3 != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        recv_cycle++;
        @(posedge clk);
      end
    end
  end

  // Check each result transaction against the oldest expectation; watch for a hang
  always @(posedge clk) begin
    deq_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (want_wr == want_rd) begin
          log_mismatch($sformatf("unexpected result popped=%0d status=%0d occupancy=%0d",
                                 popped, status, occupancy));
        end else begin
          want = want_ring[want_rd % WANT_DEPTH];
          want_rd++;
          if (popped !== want.popped || status !== want.status ||
              occupancy !== want.occupancy) begin
            log_mismatch($sformatf(
              {"expected popped=%0d status=%0d occupancy=%0d, ",
               "got popped=%0d status=%0d occupancy=%0d"},
              $signed(want.popped), want.status, want.occupancy, popped, status, occupancy));
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule
